// ===== hdl/bfeg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the bit field and exp-Golomb reader.
// Used by the front, queue, back and top-level modules; depends on nothing.
package bfeg_pkg;

    localparam int WINDOW_BITS_DEF = 128;
    localparam int MAX_FIELD_BITS  = 64;
    localparam int QUEUE_DEPTH     = 2;

    // Input action codes.
    localparam logic [2:0] ACT_PUSH      = 3'd0;
    localparam logic [2:0] ACT_READ      = 3'd1;
    localparam logic [2:0] ACT_PEEK      = 3'd2;
    localparam logic [2:0] ACT_READ_EG   = 3'd3;
    localparam logic [2:0] ACT_PEEK_EG   = 3'd4;
    localparam logic [2:0] ACT_SKIP      = 3'd5;

    // Result status codes.
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_TOO_FEW   = 3'd1;
    localparam logic [2:0] STATUS_FULL      = 3'd2;
    localparam logic [2:0] STATUS_CODE_LONG = 3'd3;
    localparam logic [2:0] STATUS_BAD_COUNT = 3'd4;

    // Classified command kinds.
    localparam logic [1:0] KIND_NOP   = 2'd0;
    localparam logic [1:0] KIND_PUSH  = 2'd1;
    localparam logic [1:0] KIND_FIELD = 2'd2;
    localparam logic [1:0] KIND_EG    = 2'd3;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic [6:0] bit_count;
    } in_item_t;

    typedef struct packed {
        logic [63:0] value;
        logic [6:0]  code_length;
        logic [2:0]  status;
        logic [7:0]  fill_level;
    } out_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       consume;
        logic       keep_value;
        logic       bad_count;
        logic [7:0] data_byte;
        logic [6:0] bit_count;
    } cmd_t;

endpackage

// ===== hdl/bfeg_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input beats and classifies each into a command.
// Depends on bfeg_pkg.
module bfeg_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  bfeg_pkg::in_item_t s_data,
    output logic              q_push,
    input  logic              q_ready,
    output bfeg_pkg::cmd_t    q_cmd
);
    import bfeg_pkg::*;

    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready;

    always_comb begin
        q_cmd            = '0;
        q_cmd.data_byte  = s_data.data_byte;
        q_cmd.bit_count  = s_data.bit_count;
        q_cmd.bad_count  = (s_data.bit_count > 7'(MAX_FIELD_BITS));
        unique case (s_data.action)
            ACT_PUSH: begin
                q_cmd.kind = KIND_PUSH;
            end
            ACT_READ: begin
                q_cmd.kind       = KIND_FIELD;
                q_cmd.consume    = 1'b1;
                q_cmd.keep_value = 1'b1;
            end
            ACT_PEEK: begin
                q_cmd.kind       = KIND_FIELD;
                q_cmd.keep_value = 1'b1;
            end
            ACT_READ_EG: begin
                q_cmd.kind    = KIND_EG;
                q_cmd.consume = 1'b1;
            end
            ACT_PEEK_EG: begin
                q_cmd.kind = KIND_EG;
            end
            ACT_SKIP: begin
                q_cmd.kind    = KIND_FIELD;
                q_cmd.consume = 1'b1;
            end
            default: begin
                q_cmd.kind = KIND_NOP;
            end
        endcase
    end

endmodule

// ===== hdl/bfeg_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the front end and the execution back end.
// Depends on bfeg_pkg.
module bfeg_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  bfeg_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop,
    output bfeg_pkg::cmd_t pop_cmd
);
    import bfeg_pkg::*;

    localparam int QP = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entries_reg [QUEUE_DEPTH];
    logic [QP-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != QC'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QP'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QP'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QP'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QP'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QC'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QC'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef ASSERT_OFF
    // The front end must never offer a command while the queue is full.
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push_valid && (count_reg == QC'(QUEUE_DEPTH))))
        else $error("command pushed into a full queue");
`endif

endmodule

// ===== hdl/bfeg_back.sv =====
`timescale 1ns / 1ps
// Back end: holds the bit window and executes commands in three steps
// (evaluate, align and consume or append, emit). Depends on bfeg_pkg.
module bfeg_back #(
    parameter int WINDOW_BITS = bfeg_pkg::WINDOW_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_pop,
    input  bfeg_pkg::cmd_t      q_cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output bfeg_pkg::out_item_t m_data
);
    import bfeg_pkg::*;

    localparam int HW = $clog2(WINDOW_BITS + 1);
    localparam int CW = (HW > 8) ? HW + 1 : 9;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_ALIGN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]             state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [WINDOW_BITS-1:0] window_reg, window_next;
    logic [HW-1:0]          bits_held_reg, bits_held_next;
    logic [2:0]             status_reg, status_next;
    logic [6:0]             off_reg, off_next;
    logic [6:0]             n_reg, n_next;
    logic [6:0]             len_reg, len_next;
    logic [6:0]             adv_reg, adv_next;
    logic [63:0]            aligned_reg, aligned_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg, m_data_next;

    logic [63:0]            top_bits;
    logic [6:0]             zeros;
    logic [CW-1:0]          held_ext;
    logic [WINDOW_BITS-1:0] window_shl;
    logic [63:0]            field;
    logic                   out_free;

    // Leading zero count by halving; an all-zero word gives 64.
    function automatic logic [6:0] lzc64(input logic [63:0] x);
        logic [63:0] v;
        logic [6:0]  c;
        v = x;
        c = 7'd0;
        if (v[63:32] == '0) begin c = c + 7'd32; v = v << 32; end
        if (v[63:48] == '0) begin c = c + 7'd16; v = v << 16; end
        if (v[63:56] == '0) begin c = c + 7'd8;  v = v << 8;  end
        if (v[63:60] == '0) begin c = c + 7'd4;  v = v << 4;  end
        if (v[63:62] == '0) begin c = c + 7'd2;  v = v << 2;  end
        if (v[63] == 1'b0)  begin c = c + 7'd1;  v = v << 1;  end
        if (v[63] == 1'b0)  begin c = c + 7'd1; end
        return c;
    endfunction

    assign top_bits   = window_reg[WINDOW_BITS-1 -: 64];
    assign zeros      = lzc64(top_bits);
    assign held_ext   = CW'(bits_held_reg);
    assign window_shl = window_reg << off_reg;
    assign field      = aligned_reg >> (7'd64 - n_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign q_pop      = q_valid && ((state_reg == S_IDLE) || ((state_reg == S_EMIT) && out_free));
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        window_next    = window_reg;
        bits_held_next = bits_held_reg;
        status_next    = status_reg;
        off_next       = off_reg;
        n_next         = n_reg;
        len_next       = len_reg;
        adv_next       = adv_reg;
        aligned_next   = aligned_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (q_pop) begin
                    cmd_next   = q_cmd;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                status_next = STATUS_OK;
                off_next    = 7'd0;
                n_next      = cmd_reg.bit_count;
                len_next    = 7'd0;
                adv_next    = 7'd0;
                unique case (cmd_reg.kind)
                    KIND_PUSH: begin
                        if (held_ext + CW'(8) > CW'(WINDOW_BITS)) begin
                            status_next = STATUS_FULL;
                        end
                    end
                    KIND_FIELD: begin
                        if (cmd_reg.bad_count) begin
                            status_next = STATUS_BAD_COUNT;
                        end else if (CW'(cmd_reg.bit_count) > held_ext) begin
                            status_next = STATUS_TOO_FEW;
                        end else begin
                            len_next = cmd_reg.bit_count;
                            adv_next = cmd_reg.consume ? cmd_reg.bit_count : 7'd0;
                        end
                    end
                    KIND_EG: begin
                        // No one bit among the first 64 positions means the code is
                        // either too long or not yet fully buffered.
                        if (zeros == 7'd64) begin
                            status_next = (held_ext >= CW'(64)) ? STATUS_CODE_LONG
                                                                : STATUS_TOO_FEW;
                        end else if (CW'({zeros, 1'b1}) > held_ext) begin
                            status_next = STATUS_TOO_FEW;
                        end else begin
                            off_next = zeros;
                            n_next   = zeros + 7'd1;
                            len_next = {zeros[5:0], 1'b1};
                            adv_next = cmd_reg.consume ? {zeros[5:0], 1'b1} : 7'd0;
                        end
                    end
                    KIND_NOP: begin
                        status_next = STATUS_OK;
                    end
                endcase
                state_next = S_ALIGN;
            end
            S_ALIGN: begin
                aligned_next = window_shl[WINDOW_BITS-1 -: 64];
                if (status_reg == STATUS_OK) begin
                    if (cmd_reg.kind == KIND_PUSH) begin
                        window_next    = window_reg |
                            ((WINDOW_BITS'(cmd_reg.data_byte) << (WINDOW_BITS - 8))
                             >> bits_held_reg);
                        bits_held_next = bits_held_reg + HW'(8);
                    end else begin
                        window_next    = window_reg << adv_reg;
                        bits_held_next = bits_held_reg - HW'(adv_reg);
                    end
                end
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.code_length = len_reg;
                    m_data_next.status      = status_reg;
                    m_data_next.fill_level  = 8'(bits_held_reg);
                    m_data_next.value       = 64'd0;
                    if (status_reg == STATUS_OK) begin
                        if (cmd_reg.kind == KIND_EG) begin
                            // The aligned bits are the one bit and the suffix.
                            m_data_next.value = field - 64'd1;
                        end else if (cmd_reg.kind == KIND_FIELD && cmd_reg.keep_value) begin
                            m_data_next.value = field;
                        end
                    end
                    if (q_pop) begin
                        cmd_next   = q_cmd;
                        state_next = S_EVAL;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            window_reg    <= '0;
            bits_held_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            bits_held_reg <= bits_held_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        status_reg  <= status_next;
        off_reg     <= off_next;
        n_reg       <= n_next;
        len_reg     <= len_next;
        adv_reg     <= adv_next;
        aligned_reg <= aligned_next;
        m_data_reg  <= m_data_next;
    end

`ifndef ASSERT_OFF
    a_held_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_held_reg <= HW'(WINDOW_BITS))
        else $error("buffered bit count exceeds the window");

    // Bits past the buffered ones must stay zero for the zero count to be right.
    a_tail_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (window_reg << bits_held_reg) == '0)
        else $error("window holds set bits beyond the buffered count");

    a_error_result_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.status != STATUS_OK) |->
            (m_data_reg.value == 64'd0) && (m_data_reg.code_length == 7'd0))
        else $error("failed item reports a value or length");
`endif

endmodule

// ===== hdl/bit_field_and_exp_golomb_reader.sv =====
`timescale 1ns / 1ps
// A result is presented after its beat passes the queue and the back end's evaluate, align
// and emit steps; a new command enters only once the last result is emitted, which waits for
// m_ready when a result is held. The 2-entry queue absorbs input beats meanwhile.
// Reset (aresetn low, synchronous) empties the queue and the bit window and drops
// any pending result.
module bit_field_and_exp_golomb_reader #(
    parameter int WINDOW_BITS = bfeg_pkg::WINDOW_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bfeg_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bfeg_pkg::out_item_t m_data
);
    import bfeg_pkg::*;

    logic q_push, q_ready, q_valid, q_pop;
    cmd_t push_cmd, pop_cmd;

    bfeg_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_ready (q_ready),
        .q_cmd   (push_cmd)
    );

    bfeg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push),
        .push_ready (q_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (pop_cmd)
    );

    bfeg_back #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_cmd   (pop_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
